// ----- hdl/ng_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ng_pkg: shared types for the noise gate
// Item, result, configuration and queue entry types used across the block.
// ----------------------------------------------------------------------------
package ng_pkg;

  localparam int SampleW    = 32;
  localparam int Q31W       = 31;
  localparam int HoldW      = 20;
  localparam int ModeW      = 3;
  localparam int CfgIdxW    = 3;
  localparam int QueueDepth = 4;

  localparam logic [Q31W-1:0] Q31Full = 31'h7FFF_FFFF;

  // Gate mode codes
  localparam logic [ModeW-1:0] ModeClosed  = 3'd0;
  localparam logic [ModeW-1:0] ModeAttack  = 3'd1;
  localparam logic [ModeW-1:0] ModeOpen    = 3'd2;
  localparam logic [ModeW-1:0] ModeHold    = 3'd3;
  localparam logic [ModeW-1:0] ModeRelease = 3'd4;

  // Register map
  localparam logic [CfgIdxW-1:0] RegEnable    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLowerThr  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegUpperThr  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRiseCoeff = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFallCoeff = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHoldLen   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegOpenStep  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegCloseStep = 3'd7;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [Q31W-1:0]           q31_t;

  typedef struct packed {
    sample_t sample_left;
    sample_t sample_right;
  } frame_t;

  typedef struct packed {
    sample_t          gated_left;
    sample_t          gated_right;
    logic [ModeW-1:0] gate_mode;
    q31_t             gate_gain;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    q31_t               value;
  } cfg_wr_t;

  typedef struct packed {
    logic             enable;
    q31_t             lower_threshold;
    q31_t             upper_threshold;
    q31_t             rise_coeff;
    q31_t             fall_coeff;
    logic [HoldW-1:0] hold_length;
    q31_t             open_step;
    q31_t             close_step;
  } cfg_t;

  // Frame plus its channel peak, as held in the queue
  typedef struct packed {
    frame_t frame;
    q31_t   peak;
  } entry_t;

endpackage
`default_nettype wire

// ----- hdl/ng_intf.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ng_intf: handshake channels of the noise gate
// Frame input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface ng_frame_if;
  logic            valid;
  logic            ready;
  ng_pkg::frame_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ng_result_if;
  logic            valid;
  logic            ready;
  ng_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ng_cfg_if;
  logic            valid;
  logic            ready;
  ng_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/ng_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ng_front: frame intake
// Accepts frames, finds the saturated absolute peak and registers the item.
// ----------------------------------------------------------------------------
module ng_front #(
  parameter int Channels = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  ng_frame_if.sink           frame_i,
  output ng_pkg::entry_t     entry_o,
  output logic               valid_o,
  input  wire logic          ready_i
);

  localparam bit UseRight = (Channels >= 2);

  logic           valid_q, valid_d;
  ng_pkg::entry_t entry_q;
  ng_pkg::q31_t   abs_l, abs_r, peak;
  logic           fire;

  // |s| with the most negative code clamped to full scale
  function automatic ng_pkg::q31_t abs_sat(input ng_pkg::sample_t s);
    logic [ng_pkg::SampleW-1:0] neg;
    neg = -s;
    if (s == 32'sh8000_0000) return ng_pkg::Q31Full;
    else if (s[ng_pkg::SampleW-1]) return neg[ng_pkg::Q31W-1:0];
    else return s[ng_pkg::Q31W-1:0];
  endfunction

  always_comb begin
    abs_l = abs_sat(frame_i.data.sample_left);
    abs_r = abs_sat(frame_i.data.sample_right);
    peak  = (UseRight && (abs_r > abs_l)) ? abs_r : abs_l;
  end

  assign frame_i.ready = !valid_q || ready_i;
  assign fire          = frame_i.valid && frame_i.ready;
  assign valid_d       = fire || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      entry_q.frame <= frame_i.data;
      entry_q.peak  <= peak;
    end
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule
`default_nettype wire

// ----- hdl/ng_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ng_queue: short decoupling queue
// Register-based FIFO between intake and processing.
// ----------------------------------------------------------------------------
module ng_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire ng_pkg::entry_t push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output ng_pkg::entry_t      pop_data_o
);

  localparam int Depth = ng_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  ng_pkg::entry_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + CntW'(1);
    else if (pop && !push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ng_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ng_back: envelope, gate state machine and gain stage
// Three-stage pipeline: envelope update, gate/ramp update, sample scaling.
// ----------------------------------------------------------------------------
module ng_back #(
  parameter int Channels = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ng_pkg::cfg_t   cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ng_pkg::entry_t in_data_i,
  ng_result_if.source         result_o
);

  localparam bit UseRight = (Channels >= 2);

  // ---- handshake chain
  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_ready, s2_ready, s3_ready;
  logic s1_fire, s2_fire, s3_fire;

  assign s3_ready   = !s3_v_q || result_o.ready;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign s1_fire    = in_valid_i && s1_ready;
  assign s2_fire    = s1_v_q && s2_ready;
  assign s3_fire    = s2_v_q && s3_ready;

  // ---- stage 1: envelope follower
  ng_pkg::frame_t       s1_frame_q;
  ng_pkg::q31_t         env_q, env_d, coeff;
  logic signed [31:0]   env_diff, env_sum;
  logic signed [63:0]   env_prod;

  always_comb begin
    coeff    = (in_data_i.peak > env_q) ? cfg_i.rise_coeff : cfg_i.fall_coeff;
    env_diff = $signed({1'b0, in_data_i.peak}) - $signed({1'b0, env_q});
    env_prod = $signed({33'd0, coeff}) * 64'(env_diff);
    // product fits in 63 bits, so bits 62:31 are the floored shift
    env_sum  = $signed({1'b0, env_q}) + $signed(env_prod[62:31]);
    env_d    = env_sum[ng_pkg::Q31W-1:0];
  end

  // ---- stage 2: gate state machine and gain ramp
  logic [ng_pkg::ModeW-1:0] mode_q, mode_d;
  ng_pkg::q31_t             gain_q, gain_d;
  logic [ng_pkg::HoldW-1:0] hold_q, hold_d;
  logic [31:0]              gain_up;
  logic signed [31:0]       gain_dn;
  logic                     env_above, env_below;

  ng_pkg::frame_t           s2_frame_q;
  logic [ng_pkg::ModeW-1:0] s2_mode_q;
  ng_pkg::q31_t             s2_gain_q;

  always_comb begin
    env_above = (env_q > cfg_i.upper_threshold);
    env_below = (env_q < cfg_i.lower_threshold);
    gain_up   = {1'b0, gain_q} + {1'b0, cfg_i.open_step};
    gain_dn   = $signed({1'b0, gain_q}) - $signed({1'b0, cfg_i.close_step});
    mode_d    = mode_q;
    gain_d    = gain_q;
    hold_d    = hold_q;
    unique case (mode_q)
      ng_pkg::ModeAttack: begin
        if (gain_up >= {1'b0, ng_pkg::Q31Full}) begin
          gain_d = ng_pkg::Q31Full;
          mode_d = ng_pkg::ModeOpen;
        end else begin
          gain_d = gain_up[ng_pkg::Q31W-1:0];
        end
      end
      ng_pkg::ModeOpen: begin
        if (env_below) begin
          hold_d = cfg_i.hold_length;
          mode_d = ng_pkg::ModeHold;
        end
      end
      ng_pkg::ModeHold: begin
        if (hold_q <= ng_pkg::HoldW'(1)) begin
          hold_d = '0;
          mode_d = ng_pkg::ModeRelease;
        end else begin
          hold_d = hold_q - ng_pkg::HoldW'(1);
        end
        if (env_above) mode_d = ng_pkg::ModeOpen;
      end
      ng_pkg::ModeRelease: begin
        if (gain_dn <= 32'sd0) begin
          gain_d = '0;
          mode_d = ng_pkg::ModeClosed;
        end else begin
          gain_d = gain_dn[ng_pkg::Q31W-1:0];
        end
        if (env_above) mode_d = ng_pkg::ModeAttack;
      end
      default: begin
        // closed, and any stray code
        mode_d = env_above ? ng_pkg::ModeAttack : ng_pkg::ModeClosed;
      end
    endcase
  end

  // ---- stage 3: apply gain
  ng_pkg::result_t    s3_q;
  ng_pkg::sample_t    gated_l, gated_r;
  logic signed [63:0] prod_l, prod_r;

  always_comb begin
    prod_l = 64'(s2_frame_q.sample_left) * $signed({33'd0, s2_gain_q});
    prod_r = 64'(s2_frame_q.sample_right) * $signed({33'd0, s2_gain_q});
    // full gain passes exactly, zero gain mutes
    if (s2_gain_q == ng_pkg::Q31Full) begin
      gated_l = s2_frame_q.sample_left;
      gated_r = s2_frame_q.sample_right;
    end else if (s2_gain_q == '0) begin
      gated_l = '0;
      gated_r = '0;
    end else begin
      gated_l = prod_l[62:31];
      gated_r = prod_r[62:31];
    end
    // missing channel is muted, except in bypass
    if (!UseRight && cfg_i.enable) gated_r = '0;
  end

  // ---- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      env_q  <= '0;
      mode_q <= ng_pkg::ModeClosed;
      gain_q <= '0;
      hold_q <= '0;
    end else begin
      s1_v_q <= s1_fire || (s1_v_q && !s2_ready);
      s2_v_q <= s2_fire || (s2_v_q && !s3_ready);
      s3_v_q <= s3_fire || (s3_v_q && !result_o.ready);
      if (s1_fire && cfg_i.enable) env_q <= env_d;
      if (s2_fire && cfg_i.enable) begin
        mode_q <= mode_d;
        gain_q <= gain_d;
        hold_q <= hold_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) s1_frame_q <= in_data_i.frame;
    if (s2_fire) begin
      s2_frame_q <= s1_frame_q;
      s2_mode_q  <= cfg_i.enable ? mode_d : mode_q;
      s2_gain_q  <= cfg_i.enable ? gain_d : ng_pkg::Q31Full;
    end
    if (s3_fire) begin
      s3_q.gated_left  <= gated_l;
      s3_q.gated_right <= gated_r;
      s3_q.gate_mode   <= s2_mode_q;
      s3_q.gate_gain   <= s2_gain_q;
    end
  end

  assign result_o.valid = s3_v_q;
  assign result_o.data  = s3_q;

endmodule
`default_nettype wire

// ----- hdl/noise_gate_envelope_fsm.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Path: a frame passes the intake register, queue, envelope stage, gate
//   stage and gain stage before its result is valid.
// Throughput: one frame per cycle unless the output stalls; the envelope
//   stage (one multiply-add fed back into its register) bounds the clock.
// Reset: registers take their defaults, the gate is closed, envelope and
//   gain are zero; the block takes frames as soon as reset is released.
// ----------------------------------------------------------------------------
// noise_gate_envelope_fsm: stereo Q31 noise gate
// Peak detector, attack/release envelope follower, five-state gate with
// hold countdown and linear gain ramp, Q31 gain multiply per channel.
// ----------------------------------------------------------------------------
module noise_gate_envelope_fsm #(
  parameter int CHANNELS = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ng_frame_if.sink    frame_i,
  ng_result_if.source result_o,
  ng_cfg_if.sink      cfg_i
);

  // Power-on register values
  localparam ng_pkg::q31_t             RstLowerThr  = 31'd2147484;
  localparam ng_pkg::q31_t             RstUpperThr  = 31'd21474836;
  localparam ng_pkg::q31_t             RstRiseCoeff = 31'd44267000;
  localparam ng_pkg::q31_t             RstFallCoeff = 31'd4469000;
  localparam logic [ng_pkg::HoldW-1:0] RstHoldLen   = 20'd4800;
  localparam ng_pkg::q31_t             RstOpenStep  = 31'd8947848;
  localparam ng_pkg::q31_t             RstCloseStep = 31'd894784;

  ng_pkg::cfg_t cfg_q;
  logic         cfg_wr;

  // Writes are always taken, unchecked: software must write only while idle.
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable          <= 1'b1;
      cfg_q.lower_threshold <= RstLowerThr;
      cfg_q.upper_threshold <= RstUpperThr;
      cfg_q.rise_coeff      <= RstRiseCoeff;
      cfg_q.fall_coeff      <= RstFallCoeff;
      cfg_q.hold_length     <= RstHoldLen;
      cfg_q.open_step       <= RstOpenStep;
      cfg_q.close_step      <= RstCloseStep;
    end else if (cfg_wr) begin
      unique case (cfg_i.data.index)
        ng_pkg::RegEnable:    cfg_q.enable          <= cfg_i.data.value[0];
        ng_pkg::RegLowerThr:  cfg_q.lower_threshold <= cfg_i.data.value;
        ng_pkg::RegUpperThr:  cfg_q.upper_threshold <= cfg_i.data.value;
        ng_pkg::RegRiseCoeff: cfg_q.rise_coeff      <= cfg_i.data.value;
        ng_pkg::RegFallCoeff: cfg_q.fall_coeff      <= cfg_i.data.value;
        ng_pkg::RegHoldLen:   cfg_q.hold_length <= cfg_i.data.value[ng_pkg::HoldW-1:0];
        ng_pkg::RegOpenStep:  cfg_q.open_step       <= cfg_i.data.value;
        ng_pkg::RegCloseStep: cfg_q.close_step      <= cfg_i.data.value;
        default:              cfg_q.enable          <= cfg_q.enable;
      endcase
    end
  end

  // Front: take the frame, compute its peak, register it.
  ng_pkg::entry_t front_entry;
  logic           front_valid, front_ready;

  ng_front #(
    .Channels (CHANNELS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_i),
    .entry_o (front_entry),
    .valid_o (front_valid),
    .ready_i (front_ready)
  );

  // Queue decouples intake from the processing pipeline so that an
  // output stall does not reach the input ready in the same cycle.
  ng_pkg::entry_t back_entry;
  logic           back_valid, back_ready;

  ng_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_entry),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_entry)
  );

  // Back: envelope, gate state, gain ramp and output register.
  ng_back #(
    .Channels (CHANNELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (back_valid),
    .in_ready_o (back_ready),
    .in_data_i  (back_entry),
    .result_o   (result_o)
  );

endmodule
`default_nettype wire
